/* hw/rtl/mxdp_pkg.sv */
// ----------------------------------------------------------------------------
// mxdp_pkg
// Shared types, constants and helper functions for the MXFP4 dot product.
// ----------------------------------------------------------------------------
package mxdp_pkg;

  localparam int TILE_K     = 128;
  localparam int GROUP_SIZE = 32;
  localparam int POS_W      = $clog2(TILE_K);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_WEIGHT = 1'd1;

  localparam logic [31:0] FP32_ONE         = 32'h3F80_0000;
  localparam logic [31:0] FP32_ZERO        = 32'h0000_0000;
  localparam logic [31:0] FP32_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP32_QUIET_BIT   = 32'h0040_0000;

  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SA,
    S_MUL_B,
    S_MUL_SB,
    S_ADD_TILE,
    S_ADD_ACC,
    S_FLUSH,
    S_MUL_GS,
    S_MUL_W,
    S_OUT
  } seq_state_t;

  // fp32 bits of an E2M1 code
  function automatic logic [31:0] e2m1_bits(input logic [3:0] code);
    logic [30:0] mag;
    case (code[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      3'd7:    mag = 31'h40C0_0000;
      default: mag = 31'h0000_0000;
    endcase
    return {code[3], mag};
  endfunction

  // E8M0: zero, infinity, or 2^(v-127); all three fall out of the shift
  function automatic logic [31:0] e8m0_bits(input logic [7:0] code);
    return {1'b0, code, 23'd0};
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] r;
    if (u[30:23] == 8'hFF && u[22:0] != 23'd0) begin
      r = {16'd0, u[31:16] | 16'h0040};
    end else begin
      r = u + 32'h0000_7FFF + {31'd0, u[16]};
      r = {16'd0, r[31:16]};
    end
    return r[15:0];
  endfunction

endpackage

/* hw/rtl/mxdp_fpu.sv */
// ----------------------------------------------------------------------------
// mxdp_fpu
// Two-stage fp32 multiply/add unit, round to nearest even, with subnormals.
// ----------------------------------------------------------------------------
module mxdp_fpu (
  input  logic                clk,
  input  mxdp_pkg::fop_t      op,
  input  logic [31:0]         opa,
  input  logic [31:0]         opb,
  output logic [31:0]         result
);
  import mxdp_pkg::*;

  // stage 1 outputs
  logic               s1_sign_r, s1_sign_nxt;
  logic               s1_zsign_r, s1_zsign_nxt;
  logic signed [11:0] s1_exp_r, s1_exp_nxt;
  logic [49:0]        s1_mant_r, s1_mant_nxt;
  logic               s1_spec_r, s1_spec_nxt;
  logic [31:0]        s1_specv_r, s1_specv_nxt;
  logic [31:0]        res_r, res_nxt;

  logic [7:0]  ea_f, eb_f;
  logic [23:0] ma, mb;
  logic [9:0]  eax, ebx;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [47:0] prod;
  logic        a_big;
  logic [9:0]  e_big, e_small;
  logic [23:0] m_big, m_small;
  logic [9:0]  d;
  logic [48:0] sm_ext, sm_shift, sm_mask;
  logic        sm_sticky;

  always_comb begin
    ea_f   = opa[30:23];
    eb_f   = opb[30:23];
    ma     = {|ea_f, opa[22:0]};
    mb     = {|eb_f, opb[22:0]};
    eax    = (ea_f == 8'd0) ? 10'd1 : {2'd0, ea_f};
    ebx    = (eb_f == 8'd0) ? 10'd1 : {2'd0, eb_f};
    nan_a  = (&ea_f) && (|opa[22:0]);
    nan_b  = (&eb_f) && (|opb[22:0]);
    inf_a  = (&ea_f) && !(|opa[22:0]);
    inf_b  = (&eb_f) && !(|opb[22:0]);
    zero_a = (opa[30:0] == 31'd0);
    zero_b = (opb[30:0] == 31'd0);
    prod   = ma * mb;

    a_big   = (opa[30:0] >= opb[30:0]);
    e_big   = a_big ? eax : ebx;
    e_small = a_big ? ebx : eax;
    m_big   = a_big ? ma : mb;
    m_small = a_big ? mb : ma;
    d       = e_big - e_small;
    sm_ext  = {m_small, 25'd0};
    sm_shift  = sm_ext >> d;
    sm_mask   = ~({49{1'b1}} << d);
    sm_sticky = |(sm_ext & sm_mask);

    s1_spec_nxt  = 1'b0;
    s1_specv_nxt = FP32_ZERO;
    if (nan_a) begin
      s1_spec_nxt  = 1'b1;
      s1_specv_nxt = opa | FP32_QUIET_BIT;
    end else if (nan_b) begin
      s1_spec_nxt  = 1'b1;
      s1_specv_nxt = opb | FP32_QUIET_BIT;
    end

    if (op == FOP_MUL) begin
      s1_sign_nxt  = opa[31] ^ opb[31];
      s1_zsign_nxt = opa[31] ^ opb[31];
      s1_exp_nxt   = $signed({2'd0, eax}) + $signed({2'd0, ebx}) - 12'sd127;
      s1_mant_nxt  = {prod, 2'b00};
      if (!nan_a && !nan_b) begin
        if ((inf_a && zero_b) || (zero_a && inf_b)) begin
          s1_spec_nxt  = 1'b1;
          s1_specv_nxt = FP32_DEFAULT_NAN;
        end else if (inf_a || inf_b) begin
          s1_spec_nxt  = 1'b1;
          s1_specv_nxt = {s1_sign_nxt, 8'hFF, 23'd0};
        end
      end
    end else begin
      s1_sign_nxt  = a_big ? opa[31] : opb[31];
      s1_zsign_nxt = opa[31] & opb[31];
      s1_exp_nxt   = $signed({2'd0, e_big});
      // jam lost bits into the lsb; enough guard bits remain below the round point
      if (opa[31] != opb[31])
        s1_mant_nxt = {1'b0, m_big, 25'd0} - {1'b0, sm_shift | {48'd0, sm_sticky}};
      else
        s1_mant_nxt = {1'b0, m_big, 25'd0} + {1'b0, sm_shift | {48'd0, sm_sticky}};
      if (!nan_a && !nan_b) begin
        if (inf_a && inf_b && (opa[31] != opb[31])) begin
          s1_spec_nxt  = 1'b1;
          s1_specv_nxt = FP32_DEFAULT_NAN;
        end else if (inf_a) begin
          s1_spec_nxt  = 1'b1;
          s1_specv_nxt = opa;
        end else if (inf_b) begin
          s1_spec_nxt  = 1'b1;
          s1_specv_nxt = opb;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_sign_r  <= s1_sign_nxt;
    s1_zsign_r <= s1_zsign_nxt;
    s1_exp_r   <= s1_exp_nxt;
    s1_mant_r  <= s1_mant_nxt;
    s1_spec_r  <= s1_spec_nxt;
    s1_specv_r <= s1_specv_nxt;
    res_r      <= res_nxt;
  end

  // stage 2: normalize, denormalize, round
  logic [5:0]         lead;
  logic signed [11:0] e_norm;
  logic [49:0]        mn, md, dmask;
  logic [11:0]        rsh;
  logic [5:0]         rsh6;
  logic               dsticky;
  logic [7:0]         e_fld;
  logic               grd, stk, inc;
  logic [30:0]        mag;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (s1_mant_r[i]) lead = 6'(i);
    end
    e_norm = s1_exp_r + $signed({6'd0, lead}) - 12'sd48;
    mn     = s1_mant_r << (6'd49 - lead);
    rsh    = 12'(12'sd1 - e_norm);
    rsh6   = (rsh > 12'd63) ? 6'd63 : rsh[5:0];
    dmask  = ~({50{1'b1}} << rsh6);
    md      = mn;
    dsticky = 1'b0;
    e_fld   = e_norm[7:0];
    if (e_norm <= 12'sd0) begin
      md      = mn >> rsh6;
      dsticky = |(mn & dmask);
      e_fld   = 8'd0;
    end
    grd = md[25];
    stk = (|md[24:0]) | dsticky;
    inc = grd & (stk | md[26]);
    mag = {e_fld, md[48:26]} + {30'd0, inc};

    if (s1_spec_r)
      res_nxt = s1_specv_r;
    else if (s1_mant_r == 50'd0)
      res_nxt = {s1_zsign_r, 31'd0};
    else if (e_norm >= 12'sd255)
      res_nxt = {s1_sign_r, 8'hFF, 23'd0};
    else
      res_nxt = {s1_sign_r, mag};
  end

  assign result = res_r;

endmodule

/* hw/rtl/mxfp4_scaled_dot_product_unit.sv */
// ----------------------------------------------------------------------------
// mxfp4_scaled_dot_product_unit
// Block-scaled MXFP4 dot product with bf16 result.
// ----------------------------------------------------------------------------
// All fp32 arithmetic runs on one shared two-stage multiply/add unit under a
// small sequencer that waits for each operation before issuing the next. An
// element costs 4 operations (three multiplies, one tile add) plus one more
// at a tile end. A last item adds up to 3 more operations (flush, global
// scale, routed weight) and an output step that loads the result register.
// The input channel stalls while an item is in work; a waiting result does
// not block the next item until the following result is ready.
module mxfp4_scaled_dot_product_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mxdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mxdp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_a_pair,
  input  logic [7:0]                         in_b_pair,
  input  logic [7:0]                         in_a_scale_code,
  input  logic [7:0]                         in_b_scale_code,
  input  logic                               in_high_valid,
  input  logic [31:0]                        in_routed_weight,
  input  logic                               in_zero_result,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        out_result_bf16
);
  import mxdp_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             hi_r, hi_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      tile_r, tile_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [31:0]      gs_r;
  logic             apply_r;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_data_r, out_data_nxt;

  logic [7:0]  a_pair_r, b_pair_r, sa_r, sb_r;
  logic        hv_r, zero_r, last_r;
  logic [31:0] weight_r;

  fop_t        f_op;
  logic [31:0] f_a, f_b, f_res;
  logic [3:0]  a_nib, b_nib;
  logic        op_done;
  logic        in_accept;
  seq_state_t  after_elem;

  mxdp_fpu u_fpu (
    .clk    (clk),
    .op     (f_op),
    .opa    (f_a),
    .opb    (f_b),
    .result (f_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign a_nib     = hi_r ? a_pair_r[7:4] : a_pair_r[3:0];
  assign b_nib     = hi_r ? b_pair_r[7:4] : b_pair_r[3:0];
  assign op_done   = (phase_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 2'd0;
      hi_r        <= 1'b0;
      pos_r       <= '0;
      acc_r       <= FP32_ZERO;
      tile_r      <= FP32_ZERO;
      gs_r        <= FP32_ONE;
      apply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hi_r        <= hi_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      tile_r      <= tile_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GLOBAL_SCALE: gs_r    <= cfg_data;
          REG_APPLY_WEIGHT: apply_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    if (in_accept) begin
      a_pair_r <= in_a_pair;
      b_pair_r <= in_b_pair;
      sa_r     <= in_a_scale_code;
      sb_r     <= in_b_scale_code;
      hv_r     <= in_high_valid;
      weight_r <= in_routed_weight;
      zero_r   <= in_zero_result;
      last_r   <= in_last;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    tile_nxt      = tile_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    f_op          = FOP_MUL;
    f_a           = prod_r;
    f_b           = FP32_ONE;

    // the open tile is empty only right after an accumulator update
    if (!hi_r && hv_r)
      after_elem = S_MUL_SA;
    else if (last_r)
      after_elem = (state_r == S_ADD_TILE) ? S_FLUSH : S_MUL_GS;
    else
      after_elem = S_IDLE;

    if (state_r != S_IDLE && state_r != S_OUT)
      phase_nxt = op_done ? 2'd0 : phase_r + 2'd1;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          hi_nxt    = 1'b0;
          phase_nxt = 2'd0;
          state_nxt = S_MUL_SA;
        end
      end
      S_MUL_SA: begin
        f_a = e2m1_bits(a_nib);
        f_b = e8m0_bits(sa_r);
        if (op_done) begin
          prod_nxt  = f_res;
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        f_b = e2m1_bits(b_nib);
        if (op_done) begin
          prod_nxt  = f_res;
          state_nxt = S_MUL_SB;
        end
      end
      S_MUL_SB: begin
        f_b = e8m0_bits(sb_r);
        if (op_done) begin
          prod_nxt  = f_res;
          state_nxt = S_ADD_TILE;
        end
      end
      S_ADD_TILE: begin
        f_op = FOP_ADD;
        f_a  = tile_r;
        f_b  = prod_r;
        if (op_done) begin
          tile_nxt = f_res;
          if (pos_r == POS_W'(TILE_K - 1)) begin
            state_nxt = S_ADD_ACC;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            hi_nxt    = 1'b1;
            state_nxt = after_elem;
          end
        end
      end
      S_ADD_ACC: begin
        f_op = FOP_ADD;
        f_a  = acc_r;
        f_b  = tile_r;
        if (op_done) begin
          acc_nxt   = f_res;
          tile_nxt  = FP32_ZERO;
          pos_nxt   = '0;
          hi_nxt    = 1'b1;
          state_nxt = after_elem;
        end
      end
      S_FLUSH: begin
        f_op = FOP_ADD;
        f_a  = acc_r;
        f_b  = tile_r;
        if (op_done) begin
          acc_nxt   = f_res;
          state_nxt = S_MUL_GS;
        end
      end
      S_MUL_GS: begin
        f_a = acc_r;
        f_b = gs_r;
        if (op_done) begin
          prod_nxt  = f_res;
          state_nxt = apply_r ? S_MUL_W : S_OUT;
        end
      end
      S_MUL_W: begin
        f_b = weight_r;
        if (op_done) begin
          prod_nxt  = f_res;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = zero_r ? 16'h0000 : to_bf16(prod_r);
          acc_nxt       = FP32_ZERO;
          tile_nxt      = FP32_ZERO;
          pos_nxt       = '0;
          phase_nxt     = 2'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_bf16 = out_data_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("sequencer phase out of range");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output step");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> phase_r == 2'd0)
    else $error("sequencer idle with operation in flight");
  a_op_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    op_done |-> (state_r != S_IDLE && state_r != S_OUT))
    else $error("arithmetic step completes outside an arithmetic state");

endmodule

/* verif/tb_mxfp4_scaled_dot_product_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mxfp4_scaled_dot_product_unit
// Self-checking bench for the MXFP4 block-scaled dot product. A bit-exact
// fp32 model (own multiply/add with round to nearest even, subnormals and
// specials) predicts each bf16 result not given in the table. A directed
// table runs first, then random dot products of random length under several
// register settings, random idles on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_mxfp4_scaled_dot_product_unit;
  import mxdp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  typedef struct {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic        hv;
    logic [31:0] w;
    logic        zr;
    logic        last;
    logic        typed;
    logic [15:0] want;
  } pair_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_a_pair;
  logic [7:0] in_b_pair;
  logic [7:0] in_a_scale_code;
  logic [7:0] in_b_scale_code;
  logic in_high_valid;
  logic [31:0] in_routed_weight;
  logic in_zero_result;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_result_bf16;

  mxfp4_scaled_dot_product_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_pair(in_a_pair), .in_b_pair(in_b_pair),
    .in_a_scale_code(in_a_scale_code), .in_b_scale_code(in_b_scale_code),
    .in_high_valid(in_high_valid), .in_routed_weight(in_routed_weight),
    .in_zero_result(in_zero_result), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_bf16(out_result_bf16)
  );

  // shadow registers and dot product state
  logic [31:0] scale_reg;
  logic        weight_on;
  logic [31:0] acc_bits;
  logic [31:0] tile_bits;
  int          tile_count;

  logic [15:0] expected_bf16[$];
  int  mismatches;
  int  results_seen;
  int  cycles;
  bit  quiet;
  bit  hold_armed;

  // ---------------- fp32 arithmetic ----------------
  function automatic bit is_nan(input logic [31:0] u);
    return u[30:23] == 8'hFF && u[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] u);
    return u[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit is_zero(input logic [31:0] u);
    return u[30:0] == 0;
  endfunction

  // value = m * 2^e
  function automatic void split(input logic [31:0] u, output logic [79:0] m, output int e);
    if (u[30:23] == 0) begin
      m = {57'd0, u[22:0]};
      e = 1 - 150;
    end else begin
      m = {56'd0, 1'b1, u[22:0]};
      e = int'(u[30:23]) - 150;
    end
  endfunction

  // round m * 2^x (m nonzero, below 2^70) to fp32, nearest even
  function automatic logic [31:0] round_pack(input logic sgn, input logic [79:0] m, input int x);
    int n, be, sh;
    logic [79:0] q, rem, half;
    logic [63:0] wide;
    n = 79;
    while (!m[n]) n--;
    be = x + n + 127;
    sh = n - 23;
    if (be < 1) begin
      sh = sh + 1 - be;
      be = 1;
    end
    if (sh <= 0) begin
      q = m << (-sh);
    end else begin
      if (sh > n + 2) sh = n + 2;
      q = m >> sh;
      rem = m & ((80'd1 << sh) - 1);
      half = 80'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    wide = (64'(be - 1) << 23) + q[63:0];
    if (wide >= 64'h7F80_0000) return {sgn, 31'h7F80_0000};
    return {sgn, wide[30:0]};
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] x, input logic [31:0] y);
    logic [79:0] mx, my;
    int ex, ey;
    logic s;
    s = x[31] ^ y[31];
    if (is_nan(x)) return x | FP32_QUIET_BIT;
    if (is_nan(y)) return y | FP32_QUIET_BIT;
    if (is_inf(x) || is_inf(y)) begin
      if (is_zero(x) || is_zero(y)) return DEFAULT_NAN;
      return {s, 31'h7F80_0000};
    end
    if (is_zero(x) || is_zero(y)) return {s, 31'd0};
    split(x, mx, ex);
    split(y, my, ey);
    return round_pack(s, mx * my, ex + ey);
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
    logic [79:0] mx, my, bx, by, mask, m;
    int ex, ey, d;
    logic sx, sy, s;
    if (is_nan(x)) return x | FP32_QUIET_BIT;
    if (is_nan(y)) return y | FP32_QUIET_BIT;
    if (is_inf(x) && is_inf(y) && x[31] != y[31]) return DEFAULT_NAN;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    if (is_zero(x) && is_zero(y)) return {x[31] & y[31], 31'd0};
    if (is_zero(x)) return y;
    if (is_zero(y)) return x;
    split(x, mx, ex);
    split(y, my, ey);
    sx = x[31];
    sy = y[31];
    if (ey > ex) begin
      {mx, my} = {my, mx};
      {ex, ey} = {ey, ex};
      {sx, sy} = {sy, sx};
    end
    d = ex - ey;
    if (d > 64) d = 64;
    bx = mx << 40;
    by = my << 40;
    mask = (80'd1 << d) - 1;
    // fold the bits shifted out into a sticky bit
    by = (by >> d) | {79'd0, (by & mask) != 0};
    if (sx == sy) begin
      m = bx + by;
      s = sx;
    end else if (bx >= by) begin
      m = bx - by;
      s = sx;
    end else begin
      m = by - bx;
      s = sy;
    end
    if (m == 0) return FP32_ZERO;
    return round_pack(s, m, ex - 40);
  endfunction

  function automatic logic [15:0] bf16_round(input logic [31:0] u);
    logic [31:0] t;
    if (is_nan(u)) return u[31:16] | 16'h0040;
    t = u + 32'h0000_7FFF + {31'd0, u[16]};
    return t[31:16];
  endfunction

  function automatic logic [31:0] e2m1_fp32(input logic [3:0] c);
    logic [15:0] hi;
    case (c[2:0])
      3'd0: hi = 16'h0000;
      3'd1: hi = 16'h3F00;
      3'd2: hi = 16'h3F80;
      3'd3: hi = 16'h3FC0;
      3'd4: hi = 16'h4000;
      3'd5: hi = 16'h4040;
      3'd6: hi = 16'h4080;
      default: hi = 16'h40C0;
    endcase
    return {c[3], hi[14:0], 16'd0};
  endfunction

  function automatic logic [31:0] e8m0_fp32(input logic [7:0] c);
    if (c == 8'd0) return FP32_ZERO;
    if (c == 8'd255) return 32'h7F80_0000;
    return {1'b0, c, 23'd0};
  endfunction

  // ---------------- dot product predictor ----------------
  task automatic add_product(input logic [3:0] a, input logic [3:0] b,
                             input logic [31:0] sa, input logic [31:0] sb);
    logic [31:0] p;
    p = fp32_mul(e2m1_fp32(a), sa);
    p = fp32_mul(p, e2m1_fp32(b));
    p = fp32_mul(p, sb);
    tile_bits = fp32_add(tile_bits, p);
    tile_count++;
    if (tile_count >= TILE_K) begin
      acc_bits = fp32_add(acc_bits, tile_bits);
      tile_bits = FP32_ZERO;
      tile_count = 0;
    end
  endtask

  task automatic accumulate_pair(input pair_item_t it);
    logic [31:0] sa, sb, r;
    sa = e8m0_fp32(it.sa);
    sb = e8m0_fp32(it.sb);
    add_product(it.a[3:0], it.b[3:0], sa, sb);
    if (it.hv) add_product(it.a[7:4], it.b[7:4], sa, sb);
    if (it.last) begin
      if (tile_count != 0) acc_bits = fp32_add(acc_bits, tile_bits);
      r = fp32_mul(acc_bits, scale_reg);
      if (weight_on) r = fp32_mul(r, it.w);
      if (it.typed) expected_bf16.push_back(it.want);
      else expected_bf16.push_back(it.zr ? 16'h0000 : bf16_round(r));
      acc_bits = FP32_ZERO;
      tile_bits = FP32_ZERO;
      tile_count = 0;
    end
  endtask

  // ---------------- clock, limit, checking ----------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_bf16.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_bf16.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_result_bf16));
      end else begin
        if (out_result_bf16 !== expected_bf16[0])
          report_mismatch($sformatf("result_bf16 got %h want %h",
                                    out_result_bf16, expected_bf16[0]));
        void'(expected_bf16.pop_front());
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && results_seen >= 30) begin
        hold_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_pair(input pair_item_t it);
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_a_pair        <= it.a;
    in_b_pair        <= it.b;
    in_a_scale_code  <= it.sa;
    in_b_scale_code  <= it.sb;
    in_high_valid    <= it.hv;
    in_routed_weight <= it.w;
    in_zero_result   <= it.zr;
    in_last          <= it.last;
    do @(posedge clk); while (in_stall);
    accumulate_pair(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_GLOBAL_SCALE) scale_reg = val;
    else weight_on = val[0];
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bf16.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_fp32();
    if ($urandom_range(0, 9) < 7)
      return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [7:0] random_scale();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(112, 142));
    return 8'($urandom);
  endfunction

  // one random dot product; scales held per group with occasional breaks
  task automatic run_dot(input int len);
    pair_item_t it;
    logic [7:0] gsa, gsb;
    for (int i = 0; i < len; i++) begin
      if (i % (GROUP_SIZE / 2) == 0) begin
        gsa = random_scale();
        gsb = random_scale();
      end
      it.a = 8'($urandom);
      it.b = 8'($urandom);
      it.sa = ($urandom_range(0, 19) == 0) ? 8'($urandom) : gsa;
      it.sb = ($urandom_range(0, 19) == 0) ? 8'($urandom) : gsb;
      it.hv = $urandom_range(0, 9) != 0;
      it.w = random_fp32();
      it.zr = $urandom_range(0, 19) == 0;
      it.last = i == len - 1;
      it.typed = 1'b0;
      it.want = '0;
      send_pair(it);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 16);
    if (r < 95) return $urandom_range(17, 70);
    return $urandom_range(64, 140);
  endfunction

  pair_item_t directed_rows[] = '{
    '{8'h22, 8'h22, 8'd127, 8'd127, 1'b1, 32'h3F80_0000, 1'b0, 1'b1, 1'b1, 16'h4000},
    '{8'h22, 8'h22, 8'd127, 8'd127, 1'b1, 32'h3F80_0000, 1'b1, 1'b1, 1'b1, 16'h0000},
    '{8'h77, 8'h77, 8'd127, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'h4290},
    '{8'hFF, 8'h77, 8'd127, 8'd127, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'hC290},
    '{8'h72, 8'hF2, 8'd127, 8'd127, 1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'h3F80},
    '{8'h22, 8'h22, 8'd0,   8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'h0000},
    '{8'h22, 8'h22, 8'd255, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'h7F80},
    '{8'h00, 8'h22, 8'd255, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'h88, 8'h13, 8'd127, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'h77, 8'h77, 8'd254, 8'd254, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'h11, 8'h11, 8'd1,   8'd1,   1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'h71, 8'h1F, 8'd1,   8'd254, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'h35, 8'h6C, 8'd130, 8'd120, 1'b1, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h4B, 8'hA9, 8'd130, 8'd120, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'hD7, 8'h2E, 8'd130, 8'd120, 1'b1, 32'h4000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'hEE, 8'h77, 8'd200, 8'd60,  1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h77, 8'h77, 8'd200, 8'd60,  1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000},
    '{8'hF7, 8'h77, 8'd255, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h77, 8'h77, 8'd255, 8'd127, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000}
  };

  logic [31:0] phase_scale[] = '{32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000,
                                 32'h7F7F_FFFF, 32'h0080_0000, 32'hBE80_0000,
                                 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001};
  logic        phase_weight[] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    int sent;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_a_pair = '0;
    in_b_pair = '0;
    in_a_scale_code = '0;
    in_b_scale_code = '0;
    in_high_valid = 1'b0;
    in_routed_weight = '0;
    in_zero_result = 1'b0;
    in_last = 1'b0;
    scale_reg = FP32_ONE;
    weight_on = 1'b0;
    acc_bits = FP32_ZERO;
    tile_bits = FP32_ZERO;
    tile_count = 0;
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_armed = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_pair(directed_rows[i]);
    drain();

    foreach (phase_scale[p]) begin
      write_reg(REG_GLOBAL_SCALE, p == 5 ? random_fp32() : phase_scale[p]);
      write_reg(REG_APPLY_WEIGHT, {31'd0, phase_weight[p]});
      // back-to-back traffic with no idles in one phase
      quiet = p == 1;
      sent = 0;
      while (sent < 80) begin
        int len;
        len = pick_len();
        run_dot(len);
        sent += len;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
